// ===== design/epcf_pkg.sv =====
// shared types, constants and helper functions for the equirectangular face classifier
// no dependencies; every other design file imports this package
package epcf_pkg;

	localparam int H_W         = 13;
	localparam int D_W         = 12;
	localparam int U_W         = 13;
	localparam int V_W         = 12;
	localparam int MAX_HEIGHT  = 4096;
	localparam int RESET_D     = 399;

	// 2 * pi in Q3.16, folded into the angle numerator
	localparam int PI2_Q16     = 411774;
	localparam int NUM_W       = 30;
	localparam int QUO_W       = 17;
	localparam int DEN_W       = 13;

	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_GAIN  = 79595;
	localparam int XY_W         = 20;
	localparam int Z_W          = 19;
	localparam int Q15_W        = 15;

	localparam int FRONT_STAGES  = 3;
	localparam int DIV_STAGES    = QUO_W;
	localparam int CORDIC_LAT    = CORDIC_STEPS + 1;
	localparam int BACK_STAGES   = 2;
	localparam int SIDE_DELAY    = DIV_STAGES + CORDIC_LAT;
	localparam int LATENCY       = FRONT_STAGES + SIDE_DELAY + BACK_STAGES;

	localparam logic [2:0] FACE_NEG_X  = 3'd0;
	localparam logic [2:0] FACE_NEG_Y  = 3'd1;
	localparam logic [2:0] FACE_POS_X  = 3'd2;
	localparam logic [2:0] FACE_POS_Y  = 3'd3;
	localparam logic [2:0] FACE_TOP    = 3'd4;
	localparam logic [2:0] FACE_BOTTOM = 3'd5;

	typedef struct packed {
		logic even;   // longitude in a sector where |cos| sets the threshold
		logic near;   // |lon| below pi/4
		logic west;   // lon negative
		logic upper;  // latitude not below zero
	} side_t;

	function automatic logic [Z_W-1:0] arctan_q16(input int unsigned i);
		logic [Z_W-1:0] r;
		case (i)
			0:       r = Z_W'(51472);
			1:       r = Z_W'(30386);
			2:       r = Z_W'(16055);
			3:       r = Z_W'(8150);
			4:       r = Z_W'(4091);
			5:       r = Z_W'(2047);
			6:       r = Z_W'(1024);
			7:       r = Z_W'(512);
			8:       r = Z_W'(256);
			9:       r = Z_W'(128);
			10:      r = Z_W'(64);
			11:      r = Z_W'(32);
			12:      r = Z_W'(16);
			13:      r = Z_W'(8);
			14:      r = Z_W'(4);
			default: r = Z_W'(2);
		endcase
		return r;
	endfunction

	// clamp at zero, round to Q1.15, saturate
	function automatic logic [Q15_W-1:0] to_q15(input logic signed [XY_W-1:0] y);
		logic [XY_W-1:0] t;
		logic [XY_W-3:0] r;
		logic [Q15_W-1:0] q;
		t = {1'b0, y[XY_W-2:0]} + XY_W'(2);
		r = t[XY_W-1:2];
		if (y[XY_W-1]) begin
			q = '0;
		end else if (r > (XY_W-2)'(32767)) begin
			q = Q15_W'(32767);
		end else begin
			q = r[Q15_W-1:0];
		end
		return q;
	endfunction

	function automatic logic [23:0] face_rgb(input logic [2:0] face);
		logic [23:0] c;
		case (face)
			FACE_NEG_X:  c = 24'hff0000;
			FACE_NEG_Y:  c = 24'h00ff00;
			FACE_POS_X:  c = 24'h0000ff;
			FACE_POS_Y:  c = 24'h00ffff;
			FACE_TOP:    c = 24'hff00ff;
			FACE_BOTTOM: c = 24'hffff00;
			default:     c = 24'h000000;
		endcase
		return c;
	endfunction

endpackage

// ===== design/epcf_front.sv =====
// front end: coordinate clamping, sector flags, period folding and angle numerators
// three pipeline stages; uses epcf_pkg
module epcf_front import epcf_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [D_W-1:0]   d,
	input  logic [U_W-1:0]   column,
	input  logic [V_W-1:0]   row,
	output logic [NUM_W-1:0] num_lon,
	output logic [NUM_W-1:0] num_lat,
	output side_t            side
);

	logic [U_W-1:0] uc_s1;
	logic [V_W-1:0] vc_s1;
	side_t          side_s1, side_s2, side_s3;
	logic [D_W-1:0] km_s2, kv_s2;
	logic [NUM_W-1:0] num_m_s3, num_v_s3;

	logic [U_W-1:0] umax, uc, lon_dist, m0, m1, m2, m3;
	logic [V_W-1:0] vc;
	logic [U_W+1:0] dist4, d3;
	logic [D_W-1:0] mr, km, kv;
	logic [31:0]    pm, pv;
	side_t          sd;

	always_comb begin
		umax  = {d, 1'b1};
		uc    = (column > umax) ? umax : column;
		vc    = (row > d) ? d : row;
		lon_dist = (uc >= {1'b0, d}) ? (uc - {1'b0, d}) : ({1'b0, d} - uc);
		dist4 = {lon_dist, 2'b00};
		d3    = {2'b00, d, 1'b0} + {3'b000, d};
		sd.near  = dist4 < {3'b000, d};
		sd.even  = sd.near || (dist4 >= d3);
		sd.west  = uc < {1'b0, d};
		sd.upper = {vc, 1'b0} <= {1'b0, d};
	end

	// u mod d, u stays below 2d+2
	always_comb begin
		m0 = uc_s1;
		m1 = (m0 >= {1'b0, d}) ? (m0 - {1'b0, d}) : m0;
		m2 = (m1 >= {1'b0, d}) ? (m1 - {1'b0, d}) : m1;
		m3 = (m2 >= {1'b0, d}) ? (m2 - {1'b0, d}) : m2;
		mr = m3[D_W-1:0];
		km = ({mr, 1'b0} > {1'b0, d}) ? (d - mr) : mr;
		kv = side_s1.upper ? vc_s1 : (d - vc_s1);
	end

	always_comb begin
		pm = 32'(km_s2) * 32'(PI2_Q16) + 32'(d);
		pv = 32'(kv_s2) * 32'(PI2_Q16) + 32'(d);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uc_s1    <= uc;
			vc_s1    <= vc;
			side_s1  <= sd;
			km_s2    <= km;
			kv_s2    <= kv;
			side_s2  <= side_s1;
			num_m_s3 <= pm[NUM_W-1:0];
			num_v_s3 <= pv[NUM_W-1:0];
			side_s3  <= side_s2;
		end
	end

	assign num_lon = num_m_s3;
	assign num_lat = num_v_s3;
	assign side    = side_s3;

endmodule

// ===== design/epcf_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// turns the angle numerator into a Q1.16 angle; uses epcf_pkg
module epcf_div import epcf_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [DEN_W-1:0] den,
	input  logic [NUM_W-1:0] num,
	output logic [QUO_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [DIV_STAGES];
	logic [QUO_W-1:0] low_s [DIV_STAGES];
	logic [QUO_W-1:0] quo_s [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [QUO_W-1:0] low_in, quo_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_in = num[NUM_W-1:QUO_W];
			assign low_in = num[QUO_W-1:0];
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign low_in = low_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign trial = {rem_in, low_in[QUO_W-1]};
		assign ge    = trial >= {1'b0, den};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
				low_s[i] <= {low_in[QUO_W-2:0], 1'b0};
				quo_s[i] <= {quo_in[QUO_W-2:0], ge};
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

// ===== design/epcf_cordic.sv =====
// sixteen-stage rotation cordic with a Q1.15 rounding stage at the end
// gives sine and cosine of a first-quadrant angle; uses epcf_pkg
module epcf_cordic import epcf_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [QUO_W-1:0]  angle,
	output logic [Q15_W-1:0]  sin_q15,
	output logic [Q15_W-1:0]  cos_q15
);

	logic signed [XY_W-1:0] x_s [CORDIC_STEPS];
	logic signed [XY_W-1:0] y_s [CORDIC_STEPS];
	logic signed [Z_W-1:0]  z_s [CORDIC_STEPS];
	logic [Q15_W-1:0]       sin_s, cos_s;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		logic signed [XY_W-1:0] x_in, y_in, dx, dy;
		logic signed [Z_W-1:0]  z_in, at;

		if (i == 0) begin : g_first
			assign x_in = XY_W'(CORDIC_GAIN);
			assign y_in = '0;
			assign z_in = signed'({2'b00, angle});
		end else begin : g_next
			assign x_in = x_s[i-1];
			assign y_in = y_s[i-1];
			assign z_in = z_s[i-1];
		end

		assign dx = y_in >>> i;
		assign dy = x_in >>> i;
		assign at = signed'(arctan_q16(i));

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_in[Z_W-1]) begin
					x_s[i] <= x_in - dx;
					y_s[i] <= y_in + dy;
					z_s[i] <= z_in - at;
				end else begin
					x_s[i] <= x_in + dx;
					y_s[i] <= y_in - dy;
					z_s[i] <= z_in + at;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s <= to_q15(y_s[CORDIC_STEPS-1]);
			cos_s <= to_q15(x_s[CORDIC_STEPS-1]);
		end
	end

	assign sin_q15 = sin_s;
	assign cos_q15 = cos_s;

endmodule

// ===== design/epcf_back.sv =====
// back end: threshold product, top and bottom tests, face and colour selection
// two pipeline stages; uses epcf_pkg
module epcf_back import epcf_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [Q15_W-1:0]  lon_sin,
	input  logic [Q15_W-1:0]  lon_cos,
	input  logic [Q15_W-1:0]  lat_sin,
	input  logic [Q15_W-1:0]  lat_cos,
	input  side_t             side,
	output logic [2:0]        face_index,
	output logic [23:0]       face_colour
);

	logic signed [31:0] lhs_s1;
	logic [29:0]        rhs_s1;
	side_t              side_s1;
	logic [2:0]         face_s2;
	logic [23:0]        colour_s2;

	logic [Q15_W-1:0]   thr;
	logic signed [31:0] mag, lhs, rhs, rhs_neg;
	logic [2:0]         face;

	// lat_sin/lat_cos were taken of the colatitude, so they swap roles here
	always_comb begin
		thr = side.even ? lon_cos : lon_sin;
		mag = signed'({2'b00, lat_cos, 15'd0});
		lhs = side.upper ? mag : -mag;
	end

	always_comb begin
		rhs     = signed'({2'b00, rhs_s1});
		rhs_neg = -rhs;
		if (lhs_s1 >= rhs) begin
			face = FACE_TOP;
		end else if (lhs_s1 < rhs_neg) begin
			face = FACE_BOTTOM;
		end else if (side_s1.even) begin
			face = side_s1.near ? FACE_POS_X : FACE_NEG_X;
		end else begin
			face = side_s1.west ? FACE_NEG_Y : FACE_POS_Y;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lhs_s1    <= lhs;
			rhs_s1    <= 30'(thr) * 30'(lat_sin);
			side_s1   <= side;
			face_s2   <= face;
			colour_s2 <= face_rgb(face);
		end
	end

	assign face_index  = face_s2;
	assign face_colour = colour_s2;

endmodule

// ===== design/equirect_pixel_cube_face_classifier.sv =====
// Classifies one equirectangular pixel per clock into a cube face and its colour. The pipeline
// is 39 stages deep: 3 front-end stages, a 17-stage divider that turns each pixel position
// into a Q1.16 angle, a 17-stage cordic for sine and cosine, and 2 compare stages. A new
// transaction is taken every cycle; the whole pipeline holds only while the output
// transaction waits. image_height is written through cfg_we/cfg_data while no pixel is in
// flight; values outside 2..4096 act as the nearest end of that range.
// top level; instantiates epcf_front, epcf_div, epcf_cordic, epcf_back; uses epcf_pkg
module equirect_pixel_cube_face_classifier import epcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_data,        // image_height
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,    // column[12:0], row[24:13], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata     // face_index[2:0], face_colour[26:3], zero pad
);

	logic [D_W-1:0]   d_q;
	logic             vld_q [LATENCY];
	side_t            side_q [SIDE_DELAY];
	logic             en;
	logic [H_W-1:0]   hc;

	logic [NUM_W-1:0] num_lon, num_lat;
	side_t            side_front;
	logic [QUO_W-1:0] ang_lon, ang_lat;
	logic [Q15_W-1:0] lon_sin, lon_cos, lat_sin, lat_cos;
	logic [2:0]       face_index;
	logic [23:0]      face_colour;

	always_comb begin
		if (cfg_data < H_W'(2)) begin
			hc = H_W'(2);
		end else if (cfg_data > H_W'(MAX_HEIGHT)) begin
			hc = H_W'(MAX_HEIGHT);
		end else begin
			hc = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= D_W'(RESET_D);
		end else if (cfg_we) begin
			d_q <= D_W'(hc - H_W'(1));
		end
	end

	assign en = !vld_q[LATENCY-1] || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LATENCY; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= s_axis_tvalid;
			for (int i = 1; i < LATENCY; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// sector flags ride alongside the divider and cordic stages
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_front;
			for (int i = 1; i < SIDE_DELAY; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	epcf_front u_front (
		.clk     (clk),
		.en      (en),
		.d       (d_q),
		.column  (s_axis_tdata[12:0]),
		.row     (s_axis_tdata[24:13]),
		.num_lon (num_lon),
		.num_lat (num_lat),
		.side    (side_front)
	);

	epcf_div u_div_lon (
		.clk (clk),
		.en  (en),
		.den ({d_q, 1'b0}),
		.num (num_lon),
		.quo (ang_lon)
	);

	epcf_div u_div_lat (
		.clk (clk),
		.en  (en),
		.den ({d_q, 1'b0}),
		.num (num_lat),
		.quo (ang_lat)
	);

	epcf_cordic u_cordic_lon (
		.clk     (clk),
		.en      (en),
		.angle   (ang_lon),
		.sin_q15 (lon_sin),
		.cos_q15 (lon_cos)
	);

	epcf_cordic u_cordic_lat (
		.clk     (clk),
		.en      (en),
		.angle   (ang_lat),
		.sin_q15 (lat_sin),
		.cos_q15 (lat_cos)
	);

	epcf_back u_back (
		.clk         (clk),
		.en          (en),
		.lon_sin     (lon_sin),
		.lon_cos     (lon_cos),
		.lat_sin     (lat_sin),
		.lat_cos     (lat_cos),
		.side        (side_q[SIDE_DELAY-1]),
		.face_index  (face_index),
		.face_colour (face_colour)
	);

	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[LATENCY-1];
	assign m_axis_tdata  = {5'd0, face_colour, face_index};

endmodule

// ===== design/epcf_checker.sv =====
// port-level checks for the face classifier, bound to the top level
// uses epcf_pkg for face codes and colours
module epcf_checker import epcf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// output transaction holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= FACE_BOTTOM)
		else $error("face index out of range");

	a_colour: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[26:3] == face_rgb(m_axis_tdata[2:0]))
		else $error("colour does not match face");

	// an empty output slot never blocks the input side
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
		else $error("input stalled with free output");

endmodule

bind equirect_pixel_cube_face_classifier epcf_checker u_epcf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/epcf_checker.sv =====
// checker for the cube face classifier: watches both stream channels, predicts each result
// and compares in order; depends on epcf_pkg for face codes, CORDIC_GAIN and MAX_HEIGHT
`timescale 1ns / 1ps
module epcf_scoreboard import epcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);
	typedef struct {
		logic [2:0]  face;
		logic [23:0] colour;
	} face_result_t;

	localparam int ATAN_TAB[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	logic [12:0]  height_reg;
	face_result_t face_queue[$];

	function automatic int q15_of(input int y);
		int r;
		if (y < 0) y = 0;
		r = (y + 2) >>> 2;
		return (r > 32767) ? 32767 : r;
	endfunction

	// sin/cos of k*pi/d, first quadrant, via rotation cordic
	function automatic void sincos_q15(input int k, input int d, output int s, output int c);
		longint num;
		int z, x, y, dx, dy;
		num = 2 * longint'(k) * 205887 + d;
		z = int'(num / (2 * longint'(d)));
		x = CORDIC_GAIN;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end
		end
		s = q15_of(y);
		c = q15_of(x);
	endfunction

	function automatic face_result_t classify_pixel(input logic [12:0] hreg,
			input logic [12:0] col, input logic [11:0] row);
		int h, d, u, v, m, lon_dist, ts, tc, thr, bs, bc, sphi, cphi;
		longint lhs, rhs;
		bit even;
		face_result_t r;
		h = hreg;
		if (h < 2) h = 2;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		d = h - 1;
		u = col;
		v = row;
		if (u > 2 * h - 1) u = 2 * h - 1;
		if (v > d) v = d;
		lon_dist = (u >= d) ? u - d : d - u;
		even = (4 * lon_dist < d) || (4 * lon_dist >= 3 * d);
		m = u % d;
		if (2 * m > d) m = d - m;
		sincos_q15(m, d, ts, tc);
		thr = even ? tc : ts;
		if (2 * v <= d) begin
			sincos_q15(v, d, bs, bc);
			sphi = bc;
		end else begin
			sincos_q15(d - v, d, bs, bc);
			sphi = -bc;
		end
		cphi = bs;
		lhs = longint'(sphi) * 32768;
		rhs = longint'(thr) * longint'(cphi);
		if (lhs >= rhs) r.face = FACE_TOP;
		else if (lhs < -rhs) r.face = FACE_BOTTOM;
		else if (even) r.face = (4 * lon_dist < d) ? FACE_POS_X : FACE_NEG_X;
		else r.face = (u < d) ? FACE_NEG_Y : FACE_POS_Y;
		case (r.face)
			FACE_NEG_X:  r.colour = 24'hff0000;
			FACE_NEG_Y:  r.colour = 24'h00ff00;
			FACE_POS_X:  r.colour = 24'h0000ff;
			FACE_POS_Y:  r.colour = 24'h00ffff;
			FACE_TOP:    r.colour = 24'hff00ff;
			default:     r.colour = 24'hffff00;
		endcase
		return r;
	endfunction

	assign pending = face_queue.size();

	always @(posedge clk or negedge arst_n) begin
		face_result_t want;
		if (!arst_n) begin
			height_reg   <= 13'd400;
			fail_count   <= 0;
			results_seen <= 0;
			face_queue.delete();
		end else begin
			if (cfg_we) height_reg <= cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				face_queue.push_back(classify_pixel(height_reg, s_axis_tdata[12:0],
					s_axis_tdata[24:13]));
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				if (face_queue.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %h", m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = face_queue.pop_front();
					if (m_axis_tdata[2:0] !== want.face || m_axis_tdata[26:3] !== want.colour
							|| m_axis_tdata[31:27] !== 5'd0) begin
						if (fail_count < 10)
							$display("mismatch: face exp %0d got %0d, colour exp %h got %h",
								want.face, m_axis_tdata[2:0], want.colour, m_axis_tdata[26:3]);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/equirect_pixel_cube_face_classifier_tb.sv =====
// stimulus and verdict for the cube face classifier: pixels over several image heights,
// bursty input and stalling output; depends on epcf_pkg, the block and epcf_scoreboard
`timescale 1ns / 1ps
module equirect_pixel_cube_face_classifier_tb import epcf_pkg::*;;
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [12:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	int          fail_count, pending, results_seen;
	int          idle_cycles;
	int          sent;
	bit          long_hold;
	logic [12:0] cur_height;

	equirect_pixel_cube_face_classifier uut (.*);
	epcf_scoreboard chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stall pattern, with a single long hold-off
	initial begin
		int mode;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (120) @(posedge clk);
				long_hold = 1'b0;
			end
			mode = (sent / 200) % 3;
			if (mode == 0) m_axis_tready <= 1'b1;
			else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
			else m_axis_tready <= ($urandom_range(0, 1) == 0);
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_pixel(input int col, input int row);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, 12'(row), 13'(col)};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	task automatic gap_maybe(input bit bursty);
		if (bursty && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain_all();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic set_height(input int h);
		cfg_we     <= 1'b1;
		cfg_data   <= 13'(h);
		@(posedge clk);
		cfg_we     <= 1'b0;
		cur_height = 13'(h);
		@(posedge clk);
	endtask

	task automatic random_pixels(input int n);
		int h;
		h = (cur_height < 2) ? 2 : ((cur_height > MAX_HEIGHT) ? MAX_HEIGHT : cur_height);
		for (int i = 0; i < n; i++) begin
			// mostly in-image pixels, some past the edges over the full field range
			if ($urandom_range(0, 9) == 0)
				send_pixel($urandom_range(0, 8191), $urandom_range(0, 4095));
			else
				send_pixel($urandom_range(0, 2 * h - 1), $urandom_range(0, h - 1));
			gap_maybe(i % 100 >= 30);
		end
	endtask

	initial begin
		int heights[8];
		heights = '{2, 3, 4096, 8191, 0, 7, 1000, 4095};
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		long_hold     = 1'b0;
		sent          = 0;
		idle_cycles   = 0;
		cur_height    = 13'd400;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: poles, edges, sector boundaries, out-of-range fields at reset height
		send_pixel(0, 0);
		send_pixel(799, 399);
		send_pixel(399, 200);
		send_pixel(0, 200);
		send_pixel(798, 200);
		send_pixel(799, 200);
		send_pixel(200, 200);
		send_pixel(600, 200);
		send_pixel(499, 200);
		send_pixel(500, 200);
		send_pixel(299, 200);
		send_pixel(100, 200);
		send_pixel(8191, 4095);
		send_pixel(4096, 2048);
		send_pixel(399, 100);
		send_pixel(399, 300);
		send_pixel(1, 1);
		send_pixel(600, 398);
		send_pixel(5000, 150);
		send_pixel(0, 4095);
		drain_all();

		// long receiver hold-off while input keeps coming
		long_hold = 1'b1;
		random_pixels(150);
		drain_all();

		foreach (heights[k]) begin
			set_height(heights[k]);
			random_pixels(140);
			drain_all();
		end
		set_height(400);
		random_pixels(80);
		drain_all();

		repeat (LATENCY * 2) @(posedge clk);
		$display("covered %0d pixels (%0d results checked) over %0d image heights",
			sent, results_seen, 10);
		$display("incl. extreme and out-of-range heights, stray coordinates and a full stall");
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
